// File: hdl/modexp_pkg.sv
// shared types and constants for the modular exponentiation block
package modexp_pkg;

   localparam int unsigned WIDTH_DEFAULT = 32;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_REDUCE,
      ST_CHECK,
      ST_MULACC,
      ST_SQUARE,
      ST_DONE
   } state_type;

   // status of the shared modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

// File: hdl/modexp_mulmod.sv
// bit-serial shift-and-add modular multiplier, one multiplier bit per cycle
module modexp_mulmod #(
   parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WIDTH-1:0]      mcand,
   input  logic [WIDTH-1:0]      mplier,
   input  logic [WIDTH:0]        modulus,
   output modexp_pkg::mul_sts_type sts,
   output logic [WIDTH-1:0]      product
);
   import modexp_pkg::*;

   localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] bits_ff, bits_in;
   logic [WIDTH-1:0] r_ff, r_in;

   logic [WIDTH+1:0] sum;
   logic [WIDTH+1:0] mod_one;
   logic [WIDTH+1:0] mod_two;
   logic [WIDTH+1:0] reduced;

   // one step: 2r + bit*a, below three times the modulus, then subtract m or 2m
   always_comb begin
      sum     = {1'b0, r_ff, 1'b0} + (bits_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      mod_one = {1'b0, modulus};
      mod_two = {modulus, 1'b0};
      if (sum >= mod_two) begin
         reduced = sum - mod_two;
      end else if (sum >= mod_one) begin
         reduced = sum - mod_one;
      end else begin
         reduced = sum;
      end
   end

   // operand load and iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      bits_in = bits_ff;
      r_in    = r_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         a_in    = mcand;
         bits_in = mplier;
         r_in    = '0;
      end else if (busy_ff) begin
         r_in    = reduced[WIDTH-1:0];
         bits_in = {bits_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      bits_ff <= bits_in;
      r_ff    <= r_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign product  = r_ff;

endmodule

// File: hdl/modexp_ctrl.sv
// square-and-multiply sequencer driving the shared modular multiplier
module modexp_ctrl #(
   parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [WIDTH-1:0]        base,
   input  logic [WIDTH-1:0]        exponent,
   input  logic [WIDTH-1:0]        modulus,
   output logic                    res_valid,
   input  logic                    res_ready,
   output logic [WIDTH-1:0]        result,
   output logic                    mul_start,
   output logic [WIDTH-1:0]        mul_mcand,
   output logic [WIDTH-1:0]        mul_mplier,
   output logic [WIDTH:0]          mul_modulus,
   input  modexp_pkg::mul_sts_type mul_sts,
   input  logic [WIDTH-1:0]        mul_product
);
   import modexp_pkg::*;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH:0]   m_ff, m_in;

   logic             e_rest_zero;
   logic             mod_is_one;
   logic [WIDTH-1:0] one_reduced;

   assign e_rest_zero = ((e_ff >> 1) == '0);
   assign mod_is_one  = (m_ff == {{WIDTH{1'b0}}, 1'b1});
   assign one_reduced = mod_is_one ? '0 : WIDTH'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (mul_sts.done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (e_ff == '0) begin
               state_in = ST_DONE;
            end else if (e_ff[0]) begin
               state_in = ST_MULACC;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_MULACC: begin
            if (mul_sts.done) state_in = e_rest_zero ? ST_DONE : ST_SQUARE;
         end
         ST_SQUARE: begin
            if (mul_sts.done) state_in = ST_CHECK;
         end
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and multiplier commands
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mul_start = 1'b0;
      mul_mcand = b_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_LOAD: begin
            // base mod m as one times base
            mul_start = 1'b1;
            mul_mcand = one_reduced;
         end
         ST_CHECK: begin
            if (e_ff != '0) begin
               mul_start = 1'b1;
               mul_mcand = e_ff[0] ? acc_ff : b_ff;
            end
         end
         ST_MULACC: begin
            mul_start = mul_sts.done && !e_rest_zero;
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // operand registers
   always_comb begin
      b_in   = b_ff;
      e_in   = e_ff;
      acc_in = acc_ff;
      m_in   = m_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               b_in = base;
               e_in = exponent;
               m_in = (modulus == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, modulus};
               // with modulus one any set exponent bit leaves zero
               if (exponent == '0 || modulus != WIDTH'(1)) begin
                  acc_in = WIDTH'(1);
               end else begin
                  acc_in = '0;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_sts.done) b_in = mul_product;
         end
         ST_MULACC: begin
            if (mul_sts.done) acc_in = mul_product;
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               b_in = mul_product;
               e_in = e_ff >> 1;
            end
         end
         default: begin
            b_in = b_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      e_ff   <= e_in;
      acc_ff <= acc_in;
      m_ff   <= m_in;
   end

   assign mul_mplier  = b_ff;
   assign mul_modulus = m_ff;
   assign result      = acc_ff;

endmodule

// File: hdl/modular_exponentiation_top.sv
// top level of the modular exponentiation block: csr, result register, sequencer, multiplier
//
//   channel   direction   payload (lowest bit up)
//   req_      in          tdata: base, exponent
//   rsp_      out         tdata: power
//   csr_      in          wdata: modulus (write only)
//
// each item first reduces the base, then checks and squares every exponent bit below the
// highest set one, multiplying into the accumulator when such a bit is set, and ends with
// the multiply of the highest set bit; the bit-serial multiplier sets the pace.
// a zero exponent still pays for the base reduction. synchronous reset sets the
// modulus to one and empties the result register, which holds a finished result
// while the next item is accepted.
module modular_exponentiation_top #(
   parameter int unsigned WIDTH = modexp_pkg::WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [((2*WIDTH+7)/8)*8-1:0]     req_tdata,  // base, exponent
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [((WIDTH+7)/8)*8-1:0]       rsp_tdata,  // power
   input  logic                             csr_we,
   input  logic [WIDTH-1:0]                 csr_wdata
);
   import modexp_pkg::*;

   localparam int unsigned RSP_BITS = ((WIDTH + 7) / 8) * 8;

   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic             res_valid;
   logic             res_ready;
   logic [WIDTH-1:0] result;
   logic             mul_start;
   logic [WIDTH-1:0] mul_mcand;
   logic [WIDTH-1:0] mul_mplier;
   logic [WIDTH:0]   mul_modulus;
   mul_sts_type      mul_sts;
   logic [WIDTH-1:0] mul_product;

   // modulus register
   assign modulus_in = csr_we ? csr_wdata : modulus_ff;

   // output register, refilled as soon as it empties or is taken
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);

   modexp_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .base        (req_tdata[WIDTH-1:0]),
      .exponent    (req_tdata[2*WIDTH-1:WIDTH]),
      .modulus     (modulus_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .result      (result),
      .mul_start   (mul_start),
      .mul_mcand   (mul_mcand),
      .mul_mplier  (mul_mplier),
      .mul_modulus (mul_modulus),
      .mul_sts     (mul_sts),
      .mul_product (mul_product)
   );

   modexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .modulus (mul_modulus),
      .sts     (mul_sts),
      .product (mul_product)
   );

   // multiplier is never restarted while it is still iterating
   assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_sts.busy)
      else $error("multiplier started while busy");

   // a started multiply keeps the unit busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      mul_start |=> mul_sts.busy)
      else $error("multiplier did not take the start");

   // an accepted item makes the block busy until its result is out
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready right after accepting an item");

   // reset leaves modulus one and no pending result
   assert property (@(posedge clock)
      reset |=> (modulus_ff == WIDTH'(1)) && !rsp_tvalid)
      else $error("bad state after reset");

endmodule

// File: test/modular_exponentiation_top_test.sv
// self-checking testbench for the modular exponentiation block
module modular_exponentiation_top_test;

   localparam int unsigned W = modexp_pkg::WIDTH_DEFAULT;

   // one request item: base in the low bits, exponent above it
   typedef struct packed {
      logic [W-1:0] exponent;
      logic [W-1:0] base;
   } power_request_type;

   // predicts each power and keeps the powers still owed by the block
   class modexp_checker_type;
      bit [W-1:0] modulus = 1;
      bit [W-1:0] pending_powers[$];
      int unsigned faults = 0;

      // right-to-left square-and-multiply, exact products at double width
      function bit [W-1:0] modpow(bit [W-1:0] base, bit [W-1:0] expo);
         bit [2*W-1:0] m;
         bit [2*W-1:0] b;
         bit [2*W-1:0] acc;
         bit [W-1:0] e;
         // a zero modulus stands for 2^W
         m = (modulus == 0) ? (2*W)'(1) << W : (2*W)'(modulus);
         b = (2*W)'(base) % m;
         acc = 1;
         e = expo;
         while (e != 0) begin
            if (e[0])
               acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
         end
         return acc[W-1:0];
      endfunction

      function void set_modulus(bit [W-1:0] value);
         modulus = value;
      endfunction

      function void note_request(bit [W-1:0] base, bit [W-1:0] expo);
         pending_powers = {pending_powers, modpow(base, expo)};
      endfunction

      function void check_power(logic [W-1:0] actual);
         bit [W-1:0] want;
         if (pending_powers.size() == 0) begin
            if (faults < 10)
               $display("error: power %h arrived with no request pending", actual);
            faults++;
            return;
         end
         want = pending_powers.pop_front();
         if (actual !== want) begin
            if (faults < 10)
               $display("error: power mismatch, expected %h, got %h", want, actual);
            faults++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [((2*W+7)/8)*8-1:0] req_tdata = '0;  // base, exponent
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [((W+7)/8)*8-1:0] rsp_tdata;          // power
   logic csr_we = 1'b0;
   logic [W-1:0] csr_wdata = '0;

   modexp_checker_type chk;
   int burst_left = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int unsigned tick = 0;

   modular_exponentiation_top #(.WIDTH(W)) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // result monitor and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         chk.check_power(rsp_tdata[W-1:0]);
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(20, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      tick <= tick + 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (tick % 7 == 0);
         default: rsp_tready <= 1'b0;
      endcase
   end

   // send one item, then either keep the burst going or open a gap
   task automatic push_item(input logic [W-1:0] base, input logic [W-1:0] expo);
      power_request_type req;
      req.base = base;
      req.exponent = expo;
      req_tvalid <= 1'b1;
      req_tdata <= req;
      do @(posedge clock); while (!req_tready);
      chk.note_request(base, expo);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   // stop sending and wait until every power has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (chk.pending_powers.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // modulus write, only while the block is idle
   task automatic write_modulus(input logic [W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      chk.set_modulus(value);
   endtask

   // mostly short exponents, a few full width ones
   function automatic logic [W-1:0] rand_exponent();
      int pick;
      int bits;
      logic [W-1:0] mask;
      logic [W-1:0] e;
      pick = $urandom_range(0, 15);
      e = $urandom;
      if (pick == 0)
         return '0;
      if (pick <= 2)
         return e;
      bits = $urandom_range(1, 10);
      mask = (W'(1) << bits) - 1;
      return (e & mask) | (mask ^ (mask >> 1));
   endfunction

   function automatic logic [W-1:0] rand_base(input logic [W-1:0] m);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 1;
         3: return m - 1;
         4: return m;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [W-1:0] rand_modulus();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 1;
         2: return 2;
         3: return '1;
         4: return $urandom_range(3, 255);
         5: return $urandom_range(256, 65535);
         6: return 46341;
         7: return $urandom | (W'(1) << (W - 1));
         default: return $urandom;
      endcase
   endfunction

   initial begin
      chk = new;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // modulus one: zero exponent still gives one, otherwise zero
      write_modulus(1);
      push_item(5, 0);
      push_item(5, 3);
      push_item(0, 0);
      push_item('1, '1);
      drain();

      // modulus zero wraps at 2^W
      write_modulus(0);
      push_item(3, 5);
      push_item('1, 2);
      push_item(2, 32);
      push_item('1, '1);
      push_item(0, 0);
      push_item(0, 5);
      drain();

      // largest modulus, base at and below it
      write_modulus('1);
      push_item('1, 1);
      push_item('1 - 1, '1);
      push_item(7, 0);
      push_item(W'(1) << (W - 1), W'(1) << (W - 1));
      drain();

      // prime modulus, fermat check
      write_modulus(32'hFFFF_FFFB);
      push_item(2, 32'hFFFF_FFFA);
      push_item(32'h1234_5678, 1);
      push_item(32'hFFFF_FFFB, 9);
      drain();

      // random phases, each with its own modulus
      for (int p = 0; p < 8; p++) begin
         write_modulus(rand_modulus());
         repeat (34) push_item(rand_base(chk.modulus), rand_exponent());
         drain();
      end

      repeat (40) @(posedge clock);
      if (chk.faults == 0 && chk.pending_powers.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit
   initial begin
      #60000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
